@@ hdl/bse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants of the bubble sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int VALUE_W           = 32;
    localparam int DEFAULT_MAX_ITEMS = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_DRAIN
    } bse_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SORT,
        CELL_SHIFT
    } bse_cell_op_t;

    typedef struct packed {
        bse_cell_op_t op;
        logic         phase;
    } bse_cell_ctl_t;

endpackage

@@ hdl/bse_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_cell
// One element slot of the sort chain: load, odd-even compare-exchange with
// its neighbors, or shift toward the head during the drain.
// ----------------------------------------------------------------------------
module bse_cell #(
    parameter int MAX_ITEMS = bse_pkg::DEFAULT_MAX_ITEMS,
    parameter int IDX       = 0,
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  logic                                 aclk,
    input  bse_pkg::bse_cell_ctl_t               ctl,
    input  logic [CNT_W-1:0]                     count,
    input  logic signed [bse_pkg::VALUE_W-1:0]   load_val,
    input  logic signed [bse_pkg::VALUE_W-1:0]   left_val,
    input  logic                                 left_gt,
    input  logic signed [bse_pkg::VALUE_W-1:0]   right_val,
    output logic signed [bse_pkg::VALUE_W-1:0]   val_out,
    output logic                                 gt_out
);
    import bse_pkg::*;

    localparam logic             IS_ODD   = 1'(IDX % 2);
    localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);
    localparam logic             HAS_LEFT = (IDX > 0);

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;
    logic                      left_role;

    assign val_out   = val_reg;
    assign gt_out    = val_reg > right_val;
    assign left_role = (IS_ODD == ctl.phase);

    always_comb begin
        val_next = val_reg;
        case (ctl.op)
            CELL_LOAD: begin
                if (count == MY_IDX) begin
                    val_next = load_val;
                end
            end
            CELL_SORT: begin
                if (left_role) begin
                    if ((NEXT_IDX < count) && gt_out) begin
                        val_next = right_val;
                    end
                end else if (HAS_LEFT && (MY_IDX < count) && left_gt) begin
                    val_next = left_val;
                end
            end
            CELL_SHIFT: begin
                val_next = right_val;
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

@@ hdl/bse_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: load beats, odd-even sort phases, drain beats.
// ----------------------------------------------------------------------------
module bse_ctrl #(
    parameter int MAX_ITEMS = bse_pkg::DEFAULT_MAX_ITEMS,
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_last,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_last_res,
    output logic                   m_dropped,
    output bse_pkg::bse_cell_ctl_t ctl,
    output logic [CNT_W-1:0]       count
);
    import bse_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    bse_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] phase_reg, phase_next;
    logic             ovf_reg, ovf_next;
    logic             full;

    assign full       = (count_reg == MAX_CNT);
    assign count      = count_reg;
    assign s_ready    = (state_reg == ST_LOAD);
    assign m_valid    = (state_reg == ST_DRAIN);
    assign m_last_res = (count_reg == ONE);
    assign m_dropped  = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            phase_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        ovf_next   = ovf_reg;
        ctl.op     = CELL_HOLD;
        ctl.phase  = phase_reg[0];
        case (state_reg)
            ST_LOAD: begin
                if (s_valid) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        ctl.op     = CELL_LOAD;
                        count_next = count_reg + ONE;
                    end
                    if (s_last) begin
                        phase_next = '0;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT: begin
                ctl.op     = CELL_SORT;
                phase_next = phase_reg + ONE;
                if ((phase_reg + ONE) >= count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (m_ready) begin
                    ctl.op     = CELL_SHIFT;
                    count_next = count_reg - ONE;
                    if (count_reg == ONE) begin
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

`ifndef SYNTH
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("load and drain active together");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_CNT)
        else $error("element count beyond capacity");

    a_drain_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (count_reg != '0))
        else $error("drain with empty store");

    a_sort_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SORT) |-> (phase_reg < count_reg))
        else $error("sort phase beyond element count");

    a_end_of_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_res) |=> (s_ready && count_reg == '0 && !ovf_reg))
        else $error("run did not clear after final beat");
`endif

endmodule

@@ hdl/bubble_sort_engine_top.sv @@
`timescale 1ns / 1ps
// A set of n stored values takes n load beats, then n odd-even sort phases
// (n >= 1), then n drain beats; m_valid rises once the last sort phase has
// ended. Drain beats wait on m_ready. One set at a time: no new value is
// taken until the final result beat of a set has drained.
// Reset (aresetn, synchronous, active low) empties the store and clears the
// dropped flag; cell contents are not reset.
// ----------------------------------------------------------------------------
// bubble_sort_engine_top
// Collects signed values, sorts them ascending in a chain of cells and
// replays them, flagging values dropped beyond capacity.
// ----------------------------------------------------------------------------
module bubble_sort_engine_top #(
    parameter int MAX_ITEMS = bse_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [bse_pkg::VALUE_W-1:0] s_value,
    input  logic                               s_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [bse_pkg::VALUE_W-1:0] m_value_res,
    output logic                               m_last_res,
    output logic                               m_dropped
);
    import bse_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    bse_cell_ctl_t             ctl;
    logic [CNT_W-1:0]          count;
    logic signed [VALUE_W-1:0] cell_val [MAX_ITEMS];
    logic                      cell_gt  [MAX_ITEMS];

    bse_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_last     (s_last),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_last_res (m_last_res),
        .m_dropped  (m_dropped),
        .ctl        (ctl),
        .count      (count)
    );

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_val;
        logic                      left_gt;
        logic signed [VALUE_W-1:0] right_val;

        if (i == 0) begin : g_head
            assign left_val = '0;
            assign left_gt  = 1'b0;
        end else begin : g_mid
            assign left_val = cell_val[i-1];
            assign left_gt  = cell_gt[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign right_val = '0;
        end else begin : g_next
            assign right_val = cell_val[i+1];
        end

        bse_cell #(
            .MAX_ITEMS (MAX_ITEMS),
            .IDX       (i),
            .CNT_W     (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .count     (count),
            .load_val  (s_value),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val_out   (cell_val[i]),
            .gt_out    (cell_gt[i])
        );
    end

    assign m_value_res = cell_val[0];

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bubble_sort_engine_top. Sets of signed values are
// fed in bursts. A scoreboard class keeps its own copy of the store, sorts
// each closed set ascending and queues the sorted beats. Every output
// beat is then checked field by field against the oldest queued beat. The
// receiver stalls on its own changing pattern and twice holds off for a long
// stretch. Random sets range from one value to past capacity.
// ----------------------------------------------------------------------------
module tb;

    import bse_pkg::*;

    localparam int CAPACITY    = DEFAULT_MAX_ITEMS;
    localparam int ITEM_TARGET = 350;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 4 * CAPACITY + 20;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_pattern_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      dropped;
    } sorted_beat_t;

    class sort_scoreboard;
        int                        capacity;
        logic signed [VALUE_W-1:0] held[$];
        logic                      overflow;
        sorted_beat_t              sorted_pending[$];
        int                        errors;

        function new(int cap);
            capacity = cap;
            overflow = 1'b0;
            errors   = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        // stable ascending sort of the held set, one beat per stored value
        function void close_set();
            logic signed [VALUE_W-1:0] t;
            sorted_beat_t              b;
            int                        n;
            n = held.size();
            for (int p = 0; p + 1 < n; p++) begin
                for (int k = 0; k + 1 < n; k++) begin
                    if (held[k] > held[k+1]) begin
                        t         = held[k];
                        held[k]   = held[k+1];
                        held[k+1] = t;
                    end
                end
            end
            for (int k = 0; k < n; k++) begin
                b.value   = held[k];
                b.last    = (k == n - 1);
                b.dropped = overflow;
                sorted_pending.push_back(b);
            end
            held.delete();
            overflow = 1'b0;
        endfunction

        function void note_input(logic signed [VALUE_W-1:0] v, logic l);
            if (held.size() < capacity)
                held.push_back(v);
            else
                overflow = 1'b1;
            if (l)
                close_set();
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] v, logic l, logic d);
            sorted_beat_t e;
            if (sorted_pending.size() == 0) begin
                flag($sformatf("unexpected beat: value %0d last %b dropped %b", v, l, d));
                return;
            end
            e = sorted_pending.pop_front();
            if (v !== e.value || l !== e.last || d !== e.dropped)
                flag($sformatf("mismatch: exp value %0d last %b dropped %b, got %0d %b %b",
                               e.value, e.last, e.dropped, v, l, d));
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value;
    logic                      s_last;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_value_res;
    logic                      m_last_res;
    logic                      m_dropped;

    sort_scoreboard sb;
    int             items_sent    = 0;
    int             burst_left    = 0;
    int             hold_requests = 0;
    int             holds_served  = 0;
    int             hold_left     = 0;
    int             mode_left     = 0;
    rx_pattern_t    rx_pattern    = RX_STEADY;
    int             cycle_count   = 0;

    always #4 aclk = ~aclk;

    bubble_sort_engine_top #(
        .MAX_ITEMS(CAPACITY)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_value_res(m_value_res),
        .m_last_res (m_last_res),
        .m_dropped  (m_dropped)
    );

    function automatic logic signed [VALUE_W-1:0] rand_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            5, 6:    v = int'($urandom_range(0, 15)) - 8;
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end
            8:       v = VAL_MAX - int'($urandom_range(0, 3));
            9:       v = VAL_MIN + int'($urandom_range(0, 3));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic sender_gap(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_value(logic signed [VALUE_W-1:0] v, logic l);
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= l;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(v, l);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            sender_gap($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.sorted_pending.size() != 0) @(posedge aclk);
    endtask

    // receiver: checks beats and drives m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result(m_value_res, m_last_res, m_dropped);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = LONG_HOLD;
            end
            if (mode_left == 0) begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_pattern)
                    RX_STEADY: m_ready <= 1'b1;
                    RX_COIN:   m_ready <= $urandom_range(0, 1);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                    default:   m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        int  set_len;
        int  r;
        logic forced_overflow;
        forced_overflow = 1'b0;
        sb      = new(CAPACITY);
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        s_last  <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single value, extremes, duplicates, reversed pair
        send_value(VAL_MIN, 1'b1);
        send_value(VAL_MAX, 1'b0);
        send_value(VAL_MIN, 1'b0);
        send_value('0, 1'b0);
        send_value(-1, 1'b0);
        send_value(1, 1'b0);
        send_value(VAL_MAX, 1'b0);
        send_value(VAL_MIN, 1'b1);
        send_value(5, 1'b0);
        send_value(-5, 1'b0);
        send_value(5, 1'b0);
        send_value(-5, 1'b0);
        send_value('0, 1'b1);
        send_value(2, 1'b0);
        send_value(1, 1'b1);

        wait_drained();
        hold_requests++;

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                set_len = $urandom_range(1, 10);
            else if (r < 88)
                set_len = $urandom_range(11, CAPACITY);
            else if (r < 96)
                set_len = $urandom_range(CAPACITY - 1, CAPACITY);
            else
                set_len = $urandom_range(CAPACITY + 1, CAPACITY + 5);
            if (!forced_overflow && items_sent > ITEM_TARGET / 2) begin
                forced_overflow = 1'b1;
                set_len         = CAPACITY + 2;
                hold_requests++;
            end
            for (int k = 0; k < set_len; k++)
                send_value(rand_value(), k == set_len - 1);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/bse_pkg.sv
hdl/bse_cell.sv
hdl/bse_ctrl.sv
hdl/bubble_sort_engine_top.sv
verif/tb.sv
